// ===== hw/rtl/dtt_pkg.sv =====
// ----------------------------------------------------------------------------
// dtt_pkg: deadline timer table package
// Transaction types, command and status codes shared by the timer table.
// ----------------------------------------------------------------------------
package dtt_pkg;

   localparam logic [2:0] CMD_ADD     = 3'd0;
   localparam logic [2:0] CMD_CANCEL  = 3'd1;
   localparam logic [2:0] CMD_REFRESH = 3'd2;
   localparam logic [2:0] CMD_RESET   = 3'd3;
   localparam logic [2:0] CMD_SWEEP   = 3'd4;
   localparam logic [2:0] CMD_DELAY   = 3'd5;
   localparam logic [2:0] CMD_ANY     = 3'd6;

   localparam logic [1:0] ST_DONE    = 2'd0;
   localparam logic [1:0] ST_REFUSED = 2'd1;
   localparam logic [1:0] ST_FULL    = 2'd2;
   localparam logic [1:0] ST_NONE    = 2'd3;

   localparam logic [31:0] ROLLBACK_RESET = 32'd3600000;

   typedef struct packed {
      logic [2:0]  cmd;
      logic [3:0]  slot;
      logic [31:0] period_ms;
      logic        recurring;
      logic        restart_now;
      logic [47:0] now_ms;
   } req_type;

   typedef struct packed {
      logic [1:0]  status;
      logic [3:0]  result_slot;
      logic [47:0] delay_ms;
      logic        front_notify;
      logic        any_armed;
      logic        last;
   } rsp_type;

endpackage

// ===== hw/rtl/deadline_timer_table.sv =====
// ----------------------------------------------------------------------------
// deadline_timer_table: table of timer slots with ordered expiry
//
//   channel   dir   handshake              payload
//   req_      in    req_valid / req_stall  req_data (req_type)
//   rsp_      out   rsp_valid / rsp_stall  rsp_data (rsp_type)
//   csr_      in    csr_valid / csr_ready  csr_data (rollback limit)
//
// Every scan walks the slots one per cycle; the deadline scans go through
// one shared ALU and the deadline/period RAM read port. Add scans for a
// free slot, then for the earliest deadline; reset and next delay scan at
// most once; cancel, refresh, the armed query and unknown codes do not scan.
// A sweep expiring k slots scans k+1 times.
// Reset is synchronous; all armed flags clear at once. A stalled result
// holds the sequencer in its emit state; no input is taken until done.
// ----------------------------------------------------------------------------
module deadline_timer_table
   import dtt_pkg::*;
#(
   parameter int TIMER_SLOTS = 16,
   parameter int TIME_BITS   = 48
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  req_type     req_data,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output rsp_type     rsp_data,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [31:0] csr_data
);

   localparam int N  = TIMER_SLOTS;
   localparam int IW = $clog2(N);
   localparam int CW = IW + 1;
   localparam int W  = TIME_BITS;

   typedef enum logic [3:0] {
      S_IDLE, S_DISP, S_RD, S_REF, S_RST1, S_RST2, S_ADDW,
      S_SW0, S_SW1, S_SCAN, S_FRONT, S_DLY, S_SWHIT, S_EMIT
   } state_type;

   typedef enum logic [1:0] {K_FREE, K_MIN, K_DUE} kind_type;

   state_type     state_ff;
   kind_type      kind_ff;
   req_type       req_ff;
   logic [CW-1:0] idx_ff;
   logic          rd_vld_ff;
   logic [IW-1:0] rd_idx_ff;
   logic [N-1:0]  armed_ff;
   logic [N-1:0]  due_ff;
   logic          ff_flag_ff;
   logic [W-1:0]  prev_ff;
   logic [31:0]   limit_ff;
   logic          found_ff;
   logic [IW-1:0] best_ff;
   logic [W-1:0]  best_dl_ff;
   logic [32:0]   best_pr_ff;
   logic [IW-1:0] tgt_ff;
   logic [W-1:0]  newdl_ff;
   logic [W-1:0]  tmp_ff;
   logic          rep_ff;
   logic          roll_ff;
   logic          fin_any_ff;
   logic [1:0]    o_st_ff;
   logic [3:0]    o_slot_ff;
   logic [47:0]   o_dl_ff;
   logic          o_fn_ff;
   logic          o_last_ff;
   logic          rsp_valid_ff;
   rsp_type       rsp_ff;

   logic [W-1:0]  now_t;
   logic [W-1:0]  pms_t;
   logic          slot_ok;
   logic [W-1:0]  dl_rd;
   logic [32:0]   pr_rd;
   logic [W-1:0]  alu_a;
   logic [W-1:0]  alu_b;
   logic [W-1:0]  alu_sum;
   logic [W-1:0]  alu_diff;
   logic          alu_lt;
   logic          alu_eq;
   logic [IW-1:0] rd_addr;
   logic          dl_we;
   logic          pr_we;
   logic [W-1:0]  dl_wdata;
   logic [32:0]   pr_wdata;
   logic          is_sweep;
   logic [N-1:0]  min_mask;
   logic          excl;
   logic          cand;
   logic          scan_done;
   logic          due_j;
   logic [N-1:0]  due_left;
   logic          tgt_leads;
   logic          emit_ok;

   assign now_t    = W'(req_ff.now_ms);
   assign pms_t    = W'(req_ff.period_ms);
   assign slot_ok  = (32'(req_ff.slot) < N);
   assign is_sweep = (req_ff.cmd == CMD_SWEEP);
   assign min_mask = is_sweep ? due_ff : armed_ff;
   assign excl     = (req_ff.cmd == CMD_ADD) || (req_ff.cmd == CMD_RESET);
   assign cand     = min_mask[rd_idx_ff] && !(excl && (rd_idx_ff == tgt_ff));
   assign scan_done = (idx_ff == CW'(N)) && !rd_vld_ff;
   assign due_j    = armed_ff[rd_idx_ff] && (roll_ff || !alu_lt);
   assign emit_ok  = !rsp_valid_ff || !rsp_stall;
   assign tgt_leads = !found_ff || alu_lt || (alu_eq && (tgt_ff < best_ff));

   always_comb begin
      due_left         = due_ff;
      due_left[tgt_ff] = 1'b0;
   end

   assign req_stall = (state_ff != S_IDLE);
   assign csr_ready = 1'b1;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   assign rd_addr = (state_ff == S_SCAN) ? idx_ff[IW-1:0] : tgt_ff;

   always_comb begin
      alu_a = '0;
      alu_b = '0;
      unique case (state_ff)
         S_SCAN: begin
            if (kind_ff == K_DUE) begin
               alu_a = now_t;
               alu_b = dl_rd;
            end else begin
               alu_a = dl_rd;
               alu_b = best_dl_ff;
            end
         end
         S_ADDW: begin
            alu_a = now_t;
            alu_b = pms_t;
         end
         S_REF: begin
            alu_a = now_t;
            alu_b = W'(pr_rd[31:0]);
         end
         S_RST1: begin
            alu_a = dl_rd;
            alu_b = W'(pr_rd[31:0]);
         end
         S_RST2: begin
            alu_a = tmp_ff;
            alu_b = pms_t;
         end
         S_FRONT: begin
            alu_a = newdl_ff;
            alu_b = best_dl_ff;
         end
         S_SW0: begin
            alu_a = prev_ff;
            alu_b = W'(limit_ff);
         end
         S_SW1: begin
            alu_a = now_t;
            alu_b = tmp_ff;
         end
         S_SWHIT: begin
            alu_a = now_t;
            alu_b = W'(best_pr_ff[31:0]);
         end
         S_DLY: begin
            alu_a = best_dl_ff;
            alu_b = now_t;
         end
         default: begin
         end
      endcase
   end

   always_comb begin
      dl_we    = 1'b0;
      pr_we    = 1'b0;
      dl_wdata = alu_sum;
      pr_wdata = {req_ff.recurring, req_ff.period_ms};
      unique case (state_ff)
         S_ADDW: begin
            dl_we = 1'b1;
            pr_we = 1'b1;
         end
         S_REF: dl_we = 1'b1;
         S_RST2: begin
            dl_we    = 1'b1;
            pr_we    = 1'b1;
            pr_wdata = {rep_ff, req_ff.period_ms};
         end
         S_SWHIT: dl_we = best_pr_ff[32];
         default: begin
         end
      endcase
   end

   dtt_alu #(.W(W)) u_alu (
      .a          (alu_a),
      .b          (alu_b),
      .sum_sat    (alu_sum),
      .diff_clamp (alu_diff),
      .lt         (alu_lt),
      .eq         (alu_eq)
   );

   dtt_ram #(.WIDTH(W), .DEPTH(N)) u_dl_ram (
      .clock   (clock),
      .wr_en   (dl_we),
      .wr_addr (tgt_ff),
      .wr_data (dl_wdata),
      .rd_addr (rd_addr),
      .rd_data (dl_rd)
   );

   dtt_ram #(.WIDTH(33), .DEPTH(N)) u_pr_ram (
      .clock   (clock),
      .wr_en   (pr_we),
      .wr_addr (tgt_ff),
      .wr_data (pr_wdata),
      .rd_addr (rd_addr),
      .rd_data (pr_rd)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         kind_ff      <= K_FREE;
         rd_vld_ff    <= 1'b0;
         armed_ff     <= '0;
         ff_flag_ff   <= 1'b0;
         prev_ff      <= '0;
         limit_ff     <= ROLLBACK_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_valid && csr_ready) begin
            limit_ff <= csr_data;
         end
         if (rsp_valid_ff && !rsp_stall && (state_ff != S_EMIT)) begin
            rsp_valid_ff <= 1'b0;
         end
         rd_vld_ff <= (state_ff == S_SCAN) && (idx_ff != CW'(N));
         rd_idx_ff <= idx_ff[IW-1:0];

         unique case (state_ff)
            S_IDLE: begin
               if (req_valid) begin
                  req_ff    <= req_data;
                  tgt_ff    <= IW'(req_data.slot);
                  o_st_ff   <= ST_DONE;
                  o_slot_ff <= '0;
                  o_dl_ff   <= '0;
                  o_fn_ff   <= 1'b0;
                  o_last_ff <= 1'b1;
                  state_ff  <= S_DISP;
               end
            end
            S_DISP: begin
               idx_ff   <= '0;
               found_ff <= 1'b0;
               priority case (req_ff.cmd)
                  CMD_ADD: begin
                     kind_ff  <= K_FREE;
                     state_ff <= S_SCAN;
                  end
                  CMD_CANCEL: begin
                     if (!slot_ok || !armed_ff[tgt_ff]) begin
                        o_st_ff <= ST_REFUSED;
                     end else begin
                        armed_ff[tgt_ff] <= 1'b0;
                     end
                     state_ff <= S_EMIT;
                  end
                  CMD_REFRESH: begin
                     if (!slot_ok || !armed_ff[tgt_ff]) begin
                        o_st_ff  <= ST_REFUSED;
                        state_ff <= S_EMIT;
                     end else begin
                        state_ff <= S_RD;
                     end
                  end
                  CMD_RESET: begin
                     if (!slot_ok) begin
                        o_st_ff  <= ST_REFUSED;
                        state_ff <= S_EMIT;
                     end else begin
                        state_ff <= S_RD;
                     end
                  end
                  CMD_SWEEP: state_ff <= S_SW0;
                  CMD_DELAY: begin
                     ff_flag_ff <= 1'b0;
                     kind_ff    <= K_MIN;
                     state_ff   <= S_SCAN;
                  end
                  CMD_ANY: state_ff <= S_EMIT;
                  default: begin
                     o_st_ff  <= ST_REFUSED;
                     state_ff <= S_EMIT;
                  end
               endcase
            end
            S_RD: begin
               state_ff <= (req_ff.cmd == CMD_REFRESH) ? S_REF : S_RST1;
            end
            S_REF: state_ff <= S_EMIT;
            S_RST1: begin
               rep_ff <= pr_rd[32];
               tmp_ff <= req_ff.restart_now ? now_t : alu_diff;
               if ((req_ff.period_ms == pr_rd[31:0]) && !req_ff.restart_now) begin
                  state_ff <= S_EMIT;
               end else if (!armed_ff[tgt_ff]) begin
                  o_st_ff  <= ST_REFUSED;
                  state_ff <= S_EMIT;
               end else begin
                  state_ff <= S_RST2;
               end
            end
            S_RST2, S_ADDW: begin
               newdl_ff <= alu_sum;
               if (state_ff == S_ADDW) begin
                  armed_ff[tgt_ff] <= 1'b1;
                  o_slot_ff        <= 4'(tgt_ff);
               end
               idx_ff   <= '0;
               found_ff <= 1'b0;
               kind_ff  <= K_MIN;
               state_ff <= S_SCAN;
            end
            S_SW0: begin
               tmp_ff   <= alu_diff;
               state_ff <= S_SW1;
            end
            S_SW1: begin
               roll_ff    <= alu_lt;
               prev_ff    <= now_t;
               fin_any_ff <= 1'b0;
               due_ff     <= '0;
               idx_ff     <= '0;
               kind_ff    <= K_DUE;
               state_ff   <= S_SCAN;
            end
            S_SCAN: begin
               if (idx_ff != CW'(N)) begin
                  idx_ff <= idx_ff + CW'(1);
               end
               unique case (kind_ff)
                  K_FREE: begin
                     if ((idx_ff != CW'(N)) && !found_ff &&
                         !armed_ff[idx_ff[IW-1:0]]) begin
                        found_ff <= 1'b1;
                        best_ff  <= idx_ff[IW-1:0];
                     end
                  end
                  K_MIN: begin
                     if (rd_vld_ff && cand && (!found_ff || alu_lt)) begin
                        found_ff   <= 1'b1;
                        best_ff    <= rd_idx_ff;
                        best_dl_ff <= dl_rd;
                        best_pr_ff <= pr_rd;
                     end
                  end
                  K_DUE: begin
                     if (rd_vld_ff) begin
                        due_ff[rd_idx_ff] <= due_j;
                        if (armed_ff[rd_idx_ff] && !(due_j && !pr_rd[32])) begin
                           fin_any_ff <= 1'b1;
                        end
                     end
                  end
                  default: begin
                  end
               endcase
               if (scan_done) begin
                  unique case (kind_ff)
                     K_FREE: begin
                        if (found_ff) begin
                           tgt_ff   <= best_ff;
                           state_ff <= S_ADDW;
                        end else begin
                           o_st_ff  <= ST_FULL;
                           state_ff <= S_EMIT;
                        end
                     end
                     K_DUE: begin
                        if (due_ff == '0) begin
                           o_st_ff  <= ST_NONE;
                           state_ff <= S_EMIT;
                        end else begin
                           idx_ff   <= '0;
                           found_ff <= 1'b0;
                           kind_ff  <= K_MIN;
                        end
                     end
                     default: begin
                        if (is_sweep) begin
                           tgt_ff   <= best_ff;
                           state_ff <= S_SWHIT;
                        end else if (req_ff.cmd == CMD_DELAY) begin
                           state_ff <= S_DLY;
                        end else begin
                           state_ff <= S_FRONT;
                        end
                     end
                  endcase
               end
            end
            S_FRONT: begin
               if (tgt_leads && !ff_flag_ff) begin
                  o_fn_ff    <= 1'b1;
                  ff_flag_ff <= 1'b1;
               end
               state_ff <= S_EMIT;
            end
            S_DLY: begin
               o_dl_ff  <= found_ff ? 48'(alu_diff) : '1;
               state_ff <= S_EMIT;
            end
            S_SWHIT: begin
               due_ff[tgt_ff] <= 1'b0;
               if (!best_pr_ff[32]) begin
                  armed_ff[tgt_ff] <= 1'b0;
               end
               o_st_ff   <= ST_DONE;
               o_slot_ff <= 4'(tgt_ff);
               o_last_ff <= (due_left == '0);
               state_ff  <= S_EMIT;
            end
            S_EMIT: begin
               if (emit_ok) begin
                  rsp_valid_ff         <= 1'b1;
                  rsp_ff.status        <= o_st_ff;
                  rsp_ff.result_slot   <= o_slot_ff;
                  rsp_ff.delay_ms      <= o_dl_ff;
                  rsp_ff.front_notify  <= o_fn_ff;
                  rsp_ff.any_armed     <= is_sweep ? fin_any_ff : (|armed_ff);
                  rsp_ff.last          <= o_last_ff;
                  if (is_sweep && !o_last_ff) begin
                     idx_ff   <= '0;
                     found_ff <= 1'b0;
                     kind_ff  <= K_MIN;
                     state_ff <= S_SCAN;
                  end else begin
                     state_ff <= S_IDLE;
                  end
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

endmodule

// ===== hw/rtl/dtt_ram.sv =====
// ----------------------------------------------------------------------------
// dtt_ram: generic single-port-write RAM
// One write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module dtt_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule

// ===== hw/rtl/dtt_alu.sv =====
// ----------------------------------------------------------------------------
// dtt_alu: shared time arithmetic unit
// Saturating add, clamped subtract and compare on one pair of time operands.
// ----------------------------------------------------------------------------
module dtt_alu #(
   parameter int W = 48
) (
   input  logic [W-1:0] a,
   input  logic [W-1:0] b,
   output logic [W-1:0] sum_sat,
   output logic [W-1:0] diff_clamp,
   output logic         lt,
   output logic         eq
);

   logic [W:0] sum;

   assign sum        = {1'b0, a} + {1'b0, b};
   assign sum_sat    = sum[W] ? '1 : sum[W-1:0];
   assign lt         = (a < b);
   assign eq         = (a == b);
   assign diff_clamp = lt ? '0 : (a - b);

endmodule

// ===== hw/rtl/dtt_checker.sv =====
// ----------------------------------------------------------------------------
// dtt_checker: port-level checks for the deadline timer table
// Watches the request and response channels over time.
// ----------------------------------------------------------------------------
module dtt_checker
   import dtt_pkg::*;
(
   input logic    clock,
   input logic    reset,
   input logic    req_valid,
   input logic    req_stall,
   input req_type req_data,
   input logic    rsp_valid,
   input logic    rsp_stall,
   input rsp_type rsp_data
);

   // one transaction in flight at a time
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("request accepted while busy");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("stalled response changed");

   a_none_is_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_data.status == ST_NONE) |-> rsp_data.last)
      else $error("empty sweep result not last");

   a_fail_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_data.status != ST_DONE) |->
         !rsp_data.front_notify && (rsp_data.delay_ms == '0))
      else $error("failed result carries data");

   // a multi-result sweep keeps the engine busy until its last result
   a_sweep_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.last |-> req_stall)
      else $error("idle before last result");

endmodule

bind deadline_timer_table dtt_checker u_dtt_checker (.*);
